>>> src/basrt_pkg.sv
// Package for the bridge converter serial reader with tare.
// Holds the phase and flow types, request and register codes, reset values and
// the command and status structs shared by the controller and the datapath.
package basrt_pkg;

    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int GAP_W      = 16;
    localparam int TIMEOUT_W  = 24;
    localparam int PULSE_W    = 2;

    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WEIGH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TARE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES  = 2'd2;

    localparam logic [GAP_W-1:0]     GAP_RESET     = 16'd107;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000000;
    localparam logic [PULSE_W-1:0]   PULSES_RESET  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WAIT   = 3'd1,
        PH_BIT_HI = 3'd2,
        PH_BIT_LO = 3'd3,
        PH_PUL_HI = 3'd4,
        PH_PUL_LO = 3'd5
    } phase_t;

    typedef enum logic {
        FL_RUN = 1'b0,
        FL_DIV = 1'b1
    } flow_t;

    typedef struct packed {
        logic wait_clear;
        logic wait_inc;
        logic bits_clear;
        logic bit_shift;
        logic shift_in;
        logic pulse_clear;
        logic pulse_inc;
        logic op_load;
        logic op_tare;
        logic tflag_set;
        logic tflag_clear;
        logic tare_load;
        logic result_load;
        logic sck;
        logic busy;
        logic done;
        logic div_start;
        logic div_store;
    } ctrl_cmd_t;

    typedef struct packed {
        logic wait_hit;
        logic last_bit;
        logic last_pulse;
        logic op_is_tare;
        logic div_busy;
    } dp_status_t;

endpackage

>>> src/basrt_in_if.sv
// Request channel: one timebase tick with its request code and data line level.
// Depends on basrt_pkg for the field widths.
interface basrt_in_if;
    logic                       valid;
    logic                       ready;
    logic [basrt_pkg::FUNC_W-1:0] func;
    logic                       dout_level;

    modport source (output valid, output func, output dout_level, input ready);
    modport sink (input valid, input func, input dout_level, output ready);
endinterface

>>> src/basrt_out_if.sv
// Result channel: the serial clock level and the read outcome for one tick.
// The reading width follows the DATA_BITS parameter.
interface basrt_out_if #(
    parameter int DATA_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic                   sck_level;
    logic                   busy_res;
    logic                   done_res;
    logic                   was_tare;
    logic [DATA_BITS-1:0]   raw_code;
    logic signed [DATA_BITS:0] weight;
    logic                   timed_out;

    modport source (
        output valid, output sck_level, output busy_res, output done_res,
        output was_tare, output raw_code, output weight, output timed_out,
        input ready
    );
    modport sink (
        input valid, input sck_level, input busy_res, input done_res,
        input was_tare, input raw_code, input weight, input timed_out,
        output ready
    );
endinterface

>>> src/basrt_cfg_if.sv
// Configuration write channel carrying a register index and write data.
// Depends on basrt_pkg for the field widths.
interface basrt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [basrt_pkg::CFG_IDX_W-1:0]  index;
    logic [basrt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/bridge_adc_serial_reader_tare.sv
// Serial reader for a 24-bit bridge converter with tare capture and weighing.
// Each request transfer is one timebase tick and yields exactly one result
// transfer carrying the serial clock level for that tick and, on the tick a
// read completes, the offset-binary reading, the timeout flag and, for a weigh,
// (reading - tare) / gap_divisor truncated toward zero. A tick is taken every
// clock cycle while the result register is free or being emptied and no
// division is running. The result of the completion tick of a weigh is held
// back until the bit-serial divider, which produces one quotient bit per
// cycle, has finished; no further tick is taken meanwhile. Configuration
// transfers are accepted in every cycle. Depends on basrt_pkg, the channel
// interfaces, basrt_ctrl, basrt_dp and basrt_div.
module bridge_adc_serial_reader_tare #(
    parameter int DATA_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    basrt_in_if.sink    req,
    basrt_out_if.source res,
    basrt_cfg_if.sink   cfg
);

    basrt_pkg::ctrl_cmd_t  cmd;
    basrt_pkg::dp_status_t status;
    logic [DATA_BITS:0]    weight_bits;

    basrt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .func       (req.func),
        .dout_level (req.dout_level),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .cmd        (cmd),
        .status     (status)
    );

    basrt_dp #(
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .sck_level (res.sck_level),
        .busy_res  (res.busy_res),
        .done_res  (res.done_res),
        .was_tare  (res.was_tare),
        .raw_code  (res.raw_code),
        .weight    (weight_bits),
        .timed_out (res.timed_out)
    );

    assign res.weight = $signed(weight_bits);

endmodule

>>> src/basrt_div.sv
// Bit-serial signed divider: (raw - tare) / gap, truncated toward zero.
// Restoring division, one quotient bit per cycle; depends on basrt_pkg.
module basrt_div #(
    parameter int DATA_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DATA_BITS-1:0]         raw,
    input  logic [DATA_BITS-1:0]         tare,
    input  logic [basrt_pkg::GAP_W-1:0]  gap,
    output logic                         busy,
    output logic [DATA_BITS:0]           quot
);

    localparam int CNT_W = $clog2(DATA_BITS);
    localparam int GW    = basrt_pkg::GAP_W;

    logic [DATA_BITS:0]   diff;
    logic [DATA_BITS-1:0] mag;
    logic [GW-1:0]        divisor;
    logic [GW:0]          trial;
    logic [GW:0]          trial_sub;
    logic                 fits;

    logic [DATA_BITS-1:0] num_reg, num_next;
    logic [GW-1:0]        rem_reg, rem_next;
    logic [GW-1:0]        div_reg, div_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 neg_reg, neg_next;

    assign diff      = {1'b0, raw} - {1'b0, tare};
    assign mag       = diff[DATA_BITS] ? (~diff[DATA_BITS-1:0] + 1'b1)
                                       : diff[DATA_BITS-1:0];
    assign divisor   = (gap == '0) ? GW'(1) : gap;
    assign trial     = {rem_reg, num_reg[DATA_BITS-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = (trial >= {1'b0, div_reg});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            num_next  = mag;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(DATA_BITS - 1);
            busy_next = 1'b1;
            neg_next  = diff[DATA_BITS];
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DATA_BITS-2:0], fits};
            rem_next = fits ? trial_sub[GW-1:0] : trial[GW-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? (~{1'b0, num_reg} + 1'b1) : {1'b0, num_reg};

endmodule

>>> src/basrt_dp.sv
// Datapath: configuration registers, wait and bit counters, shift register,
// tare store, divider and the result register. Depends on basrt_pkg, basrt_div.
module basrt_dp #(
    parameter int DATA_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  basrt_pkg::ctrl_cmd_t              cmd,
    output basrt_pkg::dp_status_t             status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [basrt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [basrt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                              sck_level,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              was_tare,
    output logic [DATA_BITS-1:0]              raw_code,
    output logic [DATA_BITS:0]                weight,
    output logic                              timed_out
);

    localparam int BIT_W = $clog2(DATA_BITS);
    localparam int TW    = basrt_pkg::TIMEOUT_W;
    localparam int PW    = basrt_pkg::PULSE_W;

    logic [basrt_pkg::GAP_W-1:0] gap_reg;
    logic [TW-1:0]               timeout_reg;
    logic [PW-1:0]               pulses_reg;

    logic [TW-1:0]        wait_reg, wait_next;
    logic [BIT_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [PW-1:0]        pulse_reg, pulse_next;
    logic [DATA_BITS-1:0] tare_reg, tare_next;
    logic                 op_tare_reg, op_tare_next;
    logic                 tflag_reg, tflag_next;

    logic                 sck_res_reg;
    logic                 busy_res_reg;
    logic                 done_res_reg;
    logic                 was_tare_reg;
    logic [DATA_BITS-1:0] raw_res_reg;
    logic [DATA_BITS:0]   weight_reg;
    logic                 timed_out_reg;

    logic [TW-1:0]        wait_plus;
    logic [TW-1:0]        limit;
    logic [PW-1:0]        pulses_eff;
    logic [PW:0]          pulse_plus;
    logic [DATA_BITS-1:0] raw;
    logic                 div_busy;
    logic [DATA_BITS:0]   div_quot;

    assign wait_plus  = wait_reg + 1'b1;
    assign limit      = (timeout_reg == '0) ? TW'(1) : timeout_reg;
    assign pulses_eff = (pulses_reg == '0) ? PW'(1) : pulses_reg;
    assign pulse_plus = {1'b0, pulse_reg} + 1'b1;
    assign raw        = {~shift_reg[DATA_BITS-1], shift_reg[DATA_BITS-2:0]};

    assign status.wait_hit   = (wait_plus >= limit);
    assign status.last_bit   = (bit_idx_reg == BIT_W'(DATA_BITS - 1));
    assign status.last_pulse = (pulse_plus >= {1'b0, pulses_eff});
    assign status.op_is_tare = op_tare_reg;
    assign status.div_busy   = div_busy;

    basrt_div #(
        .DATA_BITS (DATA_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .raw   (raw),
        .tare  (tare_reg),
        .gap   (gap_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= basrt_pkg::GAP_RESET;
            timeout_reg <= basrt_pkg::TIMEOUT_RESET;
            pulses_reg  <= basrt_pkg::PULSES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                basrt_pkg::REG_GAP:     gap_reg     <= cfg_data[basrt_pkg::GAP_W-1:0];
                basrt_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[TW-1:0];
                basrt_pkg::REG_PULSES:  pulses_reg  <= cfg_data[PW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        wait_next    = wait_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        pulse_next   = pulse_reg;
        tare_next    = tare_reg;
        op_tare_next = op_tare_reg;
        tflag_next   = tflag_reg;

        if (cmd.wait_clear)
        begin
            wait_next = '0;
        end
        else if (cmd.wait_inc)
        begin
            wait_next = wait_plus;
        end

        if (cmd.bits_clear)
        begin
            shift_next   = '0;
            bit_idx_next = '0;
        end
        else if (cmd.bit_shift)
        begin
            shift_next   = {shift_reg[DATA_BITS-2:0], cmd.shift_in};
            bit_idx_next = status.last_bit ? '0 : bit_idx_reg + 1'b1;
        end

        if (cmd.pulse_clear)
        begin
            pulse_next = '0;
        end
        else if (cmd.pulse_inc)
        begin
            pulse_next = pulse_plus[PW-1:0];
        end

        if (cmd.op_load)
        begin
            op_tare_next = cmd.op_tare;
        end

        if (cmd.tflag_set)
        begin
            tflag_next = 1'b1;
        end
        else if (cmd.tflag_clear)
        begin
            tflag_next = 1'b0;
        end

        if (cmd.tare_load)
        begin
            tare_next = raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            pulse_reg   <= '0;
            tare_reg    <= '0;
            op_tare_reg <= 1'b0;
            tflag_reg   <= 1'b0;
        end
        else
        begin
            wait_reg    <= wait_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            pulse_reg   <= pulse_next;
            tare_reg    <= tare_next;
            op_tare_reg <= op_tare_next;
            tflag_reg   <= tflag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            sck_res_reg   <= cmd.sck;
            busy_res_reg  <= cmd.busy;
            done_res_reg  <= cmd.done;
            was_tare_reg  <= cmd.done & op_tare_reg;
            raw_res_reg   <= cmd.done ? raw : '0;
            weight_reg    <= '0;
            timed_out_reg <= cmd.done & tflag_reg;
        end
        else if (cmd.div_store)
        begin
            weight_reg <= div_quot;
        end
    end

    assign sck_level = sck_res_reg;
    assign busy_res  = busy_res_reg;
    assign done_res  = done_res_reg;
    assign was_tare  = was_tare_reg;
    assign raw_code  = raw_res_reg;
    assign weight    = weight_reg;
    assign timed_out = timed_out_reg;

endmodule

>>> src/basrt_ctrl.sv
// Controller: the converter phase sequence, the data-ready detector and the
// transfer flow control. Depends on basrt_pkg for its types and codes.
module basrt_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [basrt_pkg::FUNC_W-1:0]   func,
    input  logic                           dout_level,
    output logic                           res_valid,
    input  logic                           res_ready,
    output basrt_pkg::ctrl_cmd_t           cmd,
    input  basrt_pkg::dp_status_t          status
);

    basrt_pkg::phase_t phase_reg, phase_next;
    basrt_pkg::flow_t  flow_reg, flow_next;
    logic              low_seen_reg, low_seen_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              go_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= basrt_pkg::PH_IDLE;
            flow_reg      <= basrt_pkg::FL_RUN;
            low_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flow_reg      <= flow_next;
            low_seen_reg  <= low_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        phase_next     = phase_reg;
        flow_next      = flow_reg;
        low_seen_next  = low_seen_reg;
        out_valid_next = out_valid_reg & ~res_ready;
        go_div         = 1'b0;

        req_ready = (flow_reg == basrt_pkg::FL_RUN) && (!out_valid_reg || res_ready);
        accept    = req_valid && req_ready;

        cmd.shift_in = dout_level;

        if (accept)
        begin
            cmd.busy = 1'b1;
            case (phase_reg)
                basrt_pkg::PH_WAIT:
                begin
                    if (!dout_level && low_seen_reg)
                    begin
                        low_seen_next   = 1'b0;
                        cmd.tflag_clear = 1'b1;
                        cmd.bits_clear  = 1'b1;
                        phase_next      = basrt_pkg::PH_BIT_HI;
                    end
                    else
                    begin
                        low_seen_next = !dout_level;
                        cmd.wait_inc  = 1'b1;
                        if (status.wait_hit)
                        begin
                            low_seen_next  = 1'b0;
                            cmd.tflag_set  = 1'b1;
                            cmd.bits_clear = 1'b1;
                            phase_next     = basrt_pkg::PH_BIT_HI;
                        end
                    end
                end
                basrt_pkg::PH_BIT_HI:
                begin
                    cmd.sck    = 1'b1;
                    phase_next = basrt_pkg::PH_BIT_LO;
                end
                basrt_pkg::PH_BIT_LO:
                begin
                    cmd.bit_shift = 1'b1;
                    if (status.last_bit)
                    begin
                        cmd.pulse_clear = 1'b1;
                        phase_next      = basrt_pkg::PH_PUL_HI;
                    end
                    else
                    begin
                        phase_next = basrt_pkg::PH_BIT_HI;
                    end
                end
                basrt_pkg::PH_PUL_HI:
                begin
                    cmd.sck    = 1'b1;
                    phase_next = basrt_pkg::PH_PUL_LO;
                end
                basrt_pkg::PH_PUL_LO:
                begin
                    if (status.last_pulse)
                    begin
                        cmd.done        = 1'b1;
                        cmd.pulse_clear = 1'b1;
                        phase_next      = basrt_pkg::PH_IDLE;
                        if (status.op_is_tare)
                        begin
                            cmd.tare_load = 1'b1;
                        end
                        else
                        begin
                            go_div = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.pulse_inc = 1'b1;
                        phase_next    = basrt_pkg::PH_PUL_HI;
                    end
                end
                default:
                begin
                    cmd.busy   = 1'b0;
                    phase_next = basrt_pkg::PH_IDLE;
                    if (func inside {basrt_pkg::FUNC_WEIGH, basrt_pkg::FUNC_TARE})
                    begin
                        cmd.op_load     = 1'b1;
                        cmd.op_tare     = (func == basrt_pkg::FUNC_TARE);
                        cmd.wait_clear  = 1'b1;
                        cmd.tflag_clear = 1'b1;
                        low_seen_next   = 1'b0;
                        phase_next      = basrt_pkg::PH_WAIT;
                    end
                end
            endcase

            cmd.result_load = 1'b1;
            cmd.div_start   = go_div;
            out_valid_next  = !go_div;
            flow_next       = go_div ? basrt_pkg::FL_DIV : basrt_pkg::FL_RUN;
        end
        else if (flow_reg == basrt_pkg::FL_DIV)
        begin
            if (!status.div_busy && (!out_valid_reg || res_ready))
            begin
                cmd.div_store  = 1'b1;
                out_valid_next = 1'b1;
                flow_next      = basrt_pkg::FL_RUN;
            end
        end
    end

    assign res_valid = out_valid_reg;

endmodule
